// ===== hdl/accq_pkg.sv =====
// ----------------------------------------------------------------------------
// accq_pkg
// Shared types, codes and helpers for the alarm consecutive-count qualifier.
// ----------------------------------------------------------------------------
package accq_pkg;

  // Field widths
  localparam int IDX_W   = 6;
  localparam int RUN_W   = 8;
  localparam int CNT_W   = 16;
  localparam int EVENT_W = 2;

  // Default number of alarms held in the state memory
  localparam int DEFAULT_ALARM_COUNT = 64;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EVENT_W-1:0] EV_RAISED  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_CLEARED = 2'd2;

  // One incoming sample transaction
  typedef struct packed {
    logic [IDX_W-1:0] alarm_index;
    logic             raw_active;
    logic [RUN_W-1:0] raise_needed;
    logic [RUN_W-1:0] clear_needed;
    logic             never_clears;
    logic             skip_check;
  } sample_t;

  // One result transaction
  typedef struct packed {
    logic [IDX_W-1:0]   alarm_id_out;
    logic [EVENT_W-1:0] event_res;
    logic               qualified_active;
    logic [CNT_W-1:0]   raised_total;
    logic [CNT_W-1:0]   cleared_total;
    logic [CNT_W-1:0]   active_samples;
    logic [CNT_W-1:0]   inactive_samples;
  } result_t;

  // Per-alarm state word held in memory
  typedef struct packed {
    logic             qualified;
    logic [RUN_W-1:0] raise_run;
    logic [RUN_W-1:0] clear_run;
    logic [CNT_W-1:0] raise_total;
    logic [CNT_W-1:0] clear_total;
    logic [CNT_W-1:0] active_cnt;
    logic [CNT_W-1:0] inactive_cnt;
  } entry_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_wr;   // write zero entry at the sweep address
    logic load;       // capture sample and start memory read
    logic commit;     // write back updated entry and load result
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last; // sweep address is the final entry
    logic out_free;   // result register can take a new result
  } ctl_sts_t;

  // Saturating increments
  function automatic logic [RUN_W-1:0] inc_run(input logic [RUN_W-1:0] v);
    inc_run = (v == {RUN_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] inc_cnt(input logic [CNT_W-1:0] v);
    inc_cnt = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== hdl/accq_ctrl.sv =====
// ----------------------------------------------------------------------------
// accq_ctrl
// Controller: clearing sweep after reset, sample capture and write-back.
// ----------------------------------------------------------------------------
module accq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  accq_pkg::ctl_sts_t sts,
  output accq_pkg::ctl_cmd_t cmd
);
  import accq_pkg::*;

  ctl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_stall = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // No sample taken while the memory is being cleared or an update is open
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> sample_stall)
    else $error("sample accepted outside idle");

  // A captured sample is always followed by the update cycle
  a_load_then_calc: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_CALC))
    else $error("load not followed by update");

endmodule

// ===== hdl/accq_datapath.sv =====
// ----------------------------------------------------------------------------
// accq_datapath
// Per-alarm state memory, qualification update and result register.
// ----------------------------------------------------------------------------
module accq_datapath #(
  parameter int ALARM_COUNT = accq_pkg::DEFAULT_ALARM_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  input  accq_pkg::sample_t   sample,
  input  accq_pkg::ctl_cmd_t  cmd,
  output accq_pkg::ctl_sts_t  sts,
  output logic                result_valid,
  input  logic                result_stall,
  output accq_pkg::result_t   result
);
  import accq_pkg::*;

  // Only indices reachable by the index field need storage
  localparam int DEPTH = (ALARM_COUNT < (1 << IDX_W)) ? ALARM_COUNT : (1 << IDX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t          mem [DEPTH];
  entry_t          rd_entry;
  entry_t          upd;
  sample_t         smp;
  logic [AW-1:0]   clr_addr;
  logic [AW-1:0]   smp_addr;
  logic            idx_ok;
  logic [EVENT_W-1:0] ev;
  result_t         res_next;

  assign smp_addr = smp.alarm_index[AW-1:0];
  assign idx_ok   = (32'(smp.alarm_index) < ALARM_COUNT);

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sts.clear_last = (clr_addr == AW'(DEPTH - 1));
  assign sts.out_free   = !result_valid || !result_stall;

  // Sample capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp <= sample;
    end
  end

  // State memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[clr_addr] <= '0;
    end else if (cmd.commit && idx_ok) begin
      mem[smp_addr] <= upd;
    end
    if (cmd.load) begin
      rd_entry <= mem[sample.alarm_index[AW-1:0]];
    end
  end

  // Qualification update
  always_comb begin
    upd = rd_entry;
    ev  = EV_NONE;
    if (!smp.skip_check) begin
      if (smp.raw_active) begin
        upd.active_cnt = inc_cnt(rd_entry.active_cnt);
      end else begin
        upd.inactive_cnt = inc_cnt(rd_entry.inactive_cnt);
      end
      if (rd_entry.qualified != smp.raw_active) begin
        if (smp.raw_active) begin
          upd.raise_run = inc_run(rd_entry.raise_run);
          upd.clear_run = '0;
          if (upd.raise_run == smp.raise_needed) begin
            upd.qualified   = 1'b1;
            upd.raise_total = inc_cnt(rd_entry.raise_total);
            ev              = EV_RAISED;
          end
        end else if (!smp.never_clears) begin
          upd.clear_run = inc_run(rd_entry.clear_run);
          upd.raise_run = '0;
          if (upd.clear_run == smp.clear_needed) begin
            upd.qualified   = 1'b0;
            upd.clear_total = inc_cnt(rd_entry.clear_total);
            ev              = EV_CLEARED;
          end
        end
      end else if (rd_entry.qualified) begin
        upd.clear_run = '0;
      end else begin
        upd.raise_run = '0;
      end
    end
  end

  // Result word; an unknown alarm reports zeros
  always_comb begin
    res_next              = '0;
    res_next.alarm_id_out = smp.alarm_index;
    if (idx_ok) begin
      res_next.event_res        = ev;
      res_next.qualified_active = upd.qualified;
      res_next.raised_total     = upd.raise_total;
      res_next.cleared_total    = upd.clear_total;
      res_next.active_samples   = upd.active_cnt;
      res_next.inactive_samples = upd.inactive_cnt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= res_next;
    end
  end

  // A commit always presents a result in the next cycle
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_valid)
    else $error("commit without result");

  // An unknown alarm never reports an event or a raised state
  a_unknown_quiet: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !idx_ok) |=> (result.event_res == EV_NONE && !result.qualified_active))
    else $error("unknown alarm reported activity");

endmodule

// ===== hdl/alarm_consecutive_count_qualifier.sv =====
// ----------------------------------------------------------------------------
// alarm_consecutive_count_qualifier
// Debounces periodic raw alarm samples with per-alarm consecutive counts.
// ----------------------------------------------------------------------------
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+-------------------
//  sample   | sample_valid  | sample_stall  | sample (sample_t)
//  result   | result_valid  | result_stall  | result (result_t)
//
//  Each sample is captured with the memory read, then updated with write-back
//  into memory and the result register; the registered memory read sets this.
//  After reset a clearing pass zeroes the memory, one entry per cycle, for
//  min(ALARM_COUNT, 64) entries; samples are stalled during it.
//  A stalled result holds the update cycle, and the sample input stays
//  stalled until the result register can take the new result.
// ----------------------------------------------------------------------------
module alarm_consecutive_count_qualifier #(
  parameter int ALARM_COUNT = accq_pkg::DEFAULT_ALARM_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  accq_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_stall,
  output accq_pkg::result_t result
);
  import accq_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  accq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  accq_datapath #(
    .ALARM_COUNT (ALARM_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
